[rtl/rws_pkg.sv]
// shared constants, status codes and control structs for the roulette wheel selector
`timescale 1ns / 1ps

package rws_pkg;

  // table geometry and field widths
  localparam int MAX_ENTRIES = 64;
  localparam int KEY_W       = 16;
  localparam int WIN_W       = 16;
  localparam int WGT_W       = 15;
  localparam int RND_W       = 32;
  localparam int ST_W        = 2;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int TOT_W       = $clog2(MAX_ENTRIES * (2 ** WGT_W - 1) + 1);
  localparam int PROD_W      = RND_W + TOT_W;

  // opcodes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic accept;   // capture the input item
    logic mul_en;   // form the threshold from fraction and total
    logic walk_en;  // step through one stored entry
    logic ld_out;   // move the finished result into the output register
  } rws_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic empty;      // no entries stored
    logic walk_done;  // current entry is the pick
    logic out_free;   // output register can take a result this cycle
  } rws_sts_t;

endpackage

[rtl/rws_ctrl.sv]
// controller state machine for the roulette wheel selector
`timescale 1ns / 1ps

module rws_ctrl import rws_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_opcode,
  output logic     in_stall,
  input  rws_sts_t sts,
  output rws_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_stall    = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_opcode == OP_DRAW && !sts.empty) begin
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_WALK;
      end
      S_WALK: begin
        cmd.walk_en = 1'b1;
        if (sts.walk_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/rws_dpath.sv]
// datapath: entry tables, running total, threshold multiply, walk and output register
`timescale 1ns / 1ps

module rws_dpath import rws_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_opcode,
  input  logic [KEY_W-1:0]        in_entry_key,
  input  logic signed [WIN_W-1:0] in_entry_weight,
  input  logic [RND_W-1:0]        in_random_fraction,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic [KEY_W-1:0]        out_chosen_key,
  output logic [ST_W-1:0]         out_status,
  input  rws_cmd_t                cmd,
  output rws_sts_t                sts
);

  // entry tables
  logic [KEY_W-1:0] key_mem [MAX_ENTRIES];
  logic [WGT_W-1:0] wgt_mem [MAX_ENTRIES];
  logic [KEY_W-1:0] key_rd_r;
  logic [WGT_W-1:0] wgt_rd_r;
  logic [IDX_W-1:0] rd_addr;

  logic [CNT_W-1:0] count_r;
  logic [TOT_W-1:0] total_r;
  logic [RND_W-1:0] rnd_r;
  logic [TOT_W-1:0] thr_r;
  logic [TOT_W-1:0] cum_r;
  logic [IDX_W-1:0] idx_r;
  logic [KEY_W-1:0] res_key_r;
  logic [ST_W-1:0]  res_status_r;
  logic             out_valid_r;
  logic [KEY_W-1:0] out_key_r;
  logic [ST_W-1:0]  out_status_r;

  logic [WGT_W-1:0]  wgt_in;
  logic              full;
  logic              do_write;
  logic [PROD_W-1:0] prod;
  logic [TOT_W-1:0]  cum_sum;
  logic              hit;
  logic              last;

  // clamp negative weights, table state
  assign wgt_in   = in_entry_weight[WIN_W-1] ? '0 : WGT_W'(in_entry_weight);
  assign full     = (count_r == CNT_W'(MAX_ENTRIES));
  assign do_write = cmd.accept && (in_opcode == OP_ADD) && !full;

  // threshold: high part of fraction times total; entry i wins when cum exceeds it
  assign prod = PROD_W'(rnd_r) * PROD_W'(total_r);

  // walk compare for the entry whose data sits in the read register
  assign cum_sum = cum_r + TOT_W'(wgt_rd_r);
  assign hit     = (cum_sum > thr_r);
  assign last    = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  // read address runs one entry ahead of the compare
  assign rd_addr = cmd.mul_en ? '0 : IDX_W'(idx_r + IDX_W'(1));

  assign sts.empty     = (count_r == '0);
  assign sts.walk_done = hit || last;
  assign sts.out_free  = !out_valid_r || !out_stall;

  // table write and registered read
  always_ff @(posedge clk) begin
    if (do_write) begin
      key_mem[IDX_W'(count_r)] <= in_entry_key;
      wgt_mem[IDX_W'(count_r)] <= wgt_in;
    end
    key_rd_r <= key_mem[rd_addr];
    wgt_rd_r <= wgt_mem[rd_addr];
  end

  // entry count and weight total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      total_r <= '0;
    end else if (do_write) begin
      count_r <= count_r + CNT_W'(1);
      total_r <= total_r + TOT_W'(wgt_in);
    end
  end

  // item capture, threshold, walk and pending result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rnd_r     <= in_random_fraction;
      res_key_r <= '0;
      if (in_opcode == OP_ADD) begin
        res_status_r <= full ? ST_FULL : ST_OK;
      end else begin
        res_status_r <= (count_r == '0) ? ST_EMPTY : ST_OK;
      end
    end
    if (cmd.mul_en) begin
      thr_r <= prod[PROD_W-1:RND_W];
      cum_r <= '0;
      idx_r <= '0;
    end
    if (cmd.walk_en) begin
      if (hit || last) begin
        res_key_r    <= key_rd_r;
        res_status_r <= ST_OK;
      end else begin
        idx_r <= idx_r + IDX_W'(1);
        cum_r <= cum_sum;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_key_r    <= res_key_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_chosen_key = out_key_r;
  assign out_status     = out_status_r;

endmodule

[rtl/roulette_wheel_selector_core.sv]
// Roulette wheel selector: fitness-proportionate key selection over a table of weights.
//
// Input channel (in_valid / in_stall): in_opcode 0 appends in_entry_key with
// in_entry_weight (negative weights stored as zero); in_opcode 1 draws a key
// using in_random_fraction as an unsigned Q0.32 fraction. One result item per
// input item on the output channel (out_valid / out_stall): out_chosen_key and
// out_status (ok, table full on add, table empty on draw).
// An add or an empty draw goes from acceptance straight to the done state.
// A nonempty draw first forms the threshold with a single multiply in the multiply
// state, then the walk reads one stored entry per cycle from the table memory,
// accumulating and comparing, and stops at the chosen entry or the last stored
// one, before the result moves to the output register.
// One item is in work at a time; the next item can be accepted once the
// previous result lands in the output register, so a waiting result does not
// block the next item. While the receiver stalls, the output holds; a further
// finished result waits inside until the output register frees up.
// Reset (synchronous, rst_n low) empties the table and clears the total; no
// clearing pass is needed, since only written entries are ever compared.
`timescale 1ns / 1ps

module roulette_wheel_selector_core import rws_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_opcode,
  input  logic [KEY_W-1:0]        in_entry_key,
  input  logic signed [WIN_W-1:0] in_entry_weight,
  input  logic [RND_W-1:0]        in_random_fraction,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [KEY_W-1:0]        out_chosen_key,
  output logic [ST_W-1:0]         out_status
);

  rws_cmd_t cmd;
  rws_sts_t sts;

  // controller
  rws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  rws_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_opcode          (in_opcode),
    .in_entry_key       (in_entry_key),
    .in_entry_weight    (in_entry_weight),
    .in_random_fraction (in_random_fraction),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_chosen_key     (out_chosen_key),
    .out_status         (out_status),
    .cmd                (cmd),
    .sts                (sts)
  );

  // an accepted item keeps the block busy in the following cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted on two consecutive cycles");

  // full and empty results carry a zero key
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_chosen_key == '0))
    else $error("non-ok result with nonzero key");

  // no result right after reset
  assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

[dv/roulette_wheel_selector_core_test.sv]
// self-checking testbench for the roulette wheel selector core
`timescale 1ns / 1ps

module roulette_wheel_selector_core_test;
  import rws_pkg::*;

  // one item on the input channel
  typedef struct {
    logic                    op;
    logic [KEY_W-1:0]        key;
    logic signed [WIN_W-1:0] weight;
    logic [RND_W-1:0]        frac;
  } sel_item_t;

  // one item on the result channel
  typedef struct {
    logic [KEY_W-1:0] key;
    logic [ST_W-1:0]  status;
  } pick_t;

  // flow control phases, advanced by the number of items issued
  typedef enum int {
    PH_STREAM,
    PH_SEND_GAPS,
    PH_RECV_STALLS,
    PH_BOTH_IDLE
  } flow_phase_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_opcode;
  logic [KEY_W-1:0]        in_entry_key;
  logic signed [WIN_W-1:0] in_entry_weight;
  logic [RND_W-1:0]        in_random_fraction;
  logic                    out_valid;
  logic                    out_stall;
  logic [KEY_W-1:0]        out_chosen_key;
  logic [ST_W-1:0]         out_status;

  sel_item_t stim_items[$];
  pick_t     pending_picks[$];
  int        issued_count = 0;
  int        taken_count = 0;
  int        total_items = 0;
  int        mismatch_count = 0;

  // predicted table contents
  logic [KEY_W-1:0] table_keys[MAX_ENTRIES];
  logic [WGT_W-1:0] table_wts[MAX_ENTRIES];
  int               table_count = 0;
  logic [63:0]      table_total = '0;

  // running cumulative weights of the queued adds, for aiming draws at boundaries
  longint gen_cum[MAX_ENTRIES];
  int     gen_count = 0;

  roulette_wheel_selector_core uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_entry_key       (in_entry_key),
    .in_entry_weight    (in_entry_weight),
    .in_random_fraction (in_random_fraction),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_chosen_key     (out_chosen_key),
    .out_status         (out_status)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic flow_phase_t current_phase();
    return flow_phase_t'((issued_count / 50) % 4);
  endfunction

  // expected result of one item, updating the predicted table
  function automatic pick_t predict_pick(logic op, logic [KEY_W-1:0] key,
                                         logic signed [WIN_W-1:0] weight,
                                         logic [RND_W-1:0] frac);
    pick_t       res;
    logic [63:0] target;
    logic [63:0] cum;
    bit          found;
    res.key = '0;
    res.status = ST_OK;
    if (op == OP_ADD) begin
      if (table_count >= MAX_ENTRIES) begin
        res.status = ST_FULL;
      end else begin
        table_keys[table_count] = key;
        table_wts[table_count] = weight[WIN_W-1] ? '0 : weight[WGT_W-1:0];
        table_total += 64'(table_wts[table_count]);
        table_count++;
      end
    end else if (table_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      // first entry whose cumulative weight, scaled by 2^32, exceeds frac * total
      target = 64'(frac) * table_total;
      cum = '0;
      found = 1'b0;
      for (int i = 0; i < table_count; i++) begin
        cum += 64'(table_wts[i]);
        if (!found && (cum << 32) > target) begin
          res.key = table_keys[i];
          found = 1'b1;
        end
      end
      if (!found) res.key = table_keys[table_count-1];
    end
    return res;
  endfunction

  task automatic push_add(logic [KEY_W-1:0] key, logic signed [WIN_W-1:0] weight);
    sel_item_t it;
    longint    w;
    it.op = OP_ADD;
    it.key = key;
    it.weight = weight;
    it.frac = $urandom;
    stim_items.insert(stim_items.size(), it);
    if (gen_count < MAX_ENTRIES) begin
      w = weight[WIN_W-1] ? 0 : longint'(weight[WGT_W-1:0]);
      gen_cum[gen_count] = (gen_count == 0) ? w : gen_cum[gen_count-1] + w;
      gen_count++;
    end
  endtask

  task automatic push_draw(logic [RND_W-1:0] frac);
    sel_item_t it;
    it.op = OP_DRAW;
    it.key = KEY_W'($urandom);
    it.weight = WIN_W'($urandom);
    it.frac = frac;
    stim_items.insert(stim_items.size(), it);
  endtask

  // fraction just around the point where entry idx stops winning
  function automatic logic [RND_W-1:0] boundary_frac(int idx, int delta);
    longint t;
    longint v;
    if (gen_count == 0) return $urandom;
    t = gen_cum[gen_count-1];
    if (t == 0) return $urandom;
    v = (gen_cum[idx] <<< 32) / t + delta;
    if (v < 0) v = 0;
    if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
    return v[RND_W-1:0];
  endfunction

  // driver: inputs and receiver stall change on the falling edge
  always @(negedge clk) begin
    sel_item_t cur;
    flow_phase_t ph;
    if (rst_n) begin
      ph = current_phase();
      if (taken_count == issued_count) begin
        if (stim_items.size() != 0 &&
            !((ph == PH_SEND_GAPS && $urandom_range(0, 99) < 87) ||
              (ph == PH_BOTH_IDLE && $urandom_range(0, 99) < 16))) begin
          cur = stim_items.pop_front();
          in_valid <= 1'b1;
          in_opcode <= cur.op;
          in_entry_key <= cur.key;
          in_entry_weight <= cur.weight;
          in_random_fraction <= cur.frac;
          issued_count++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= (ph == PH_RECV_STALLS && $urandom_range(0, 99) < 87) ||
                   (ph == PH_BOTH_IDLE && $urandom_range(0, 99) < 16);
    end
  end

  // monitor: predicts on accepted items, checks accepted results
  always @(posedge clk) begin
    pick_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pending_picks.insert(pending_picks.size(),
                             predict_pick(in_opcode, in_entry_key, in_entry_weight,
                                          in_random_fraction));
        taken_count++;
      end
      if (out_valid && !out_stall) begin
        if (pending_picks.size() == 0) begin
          $error("result with nothing pending: chosen_key %h status %0d",
                 out_chosen_key, out_status);
          mismatch_count++;
        end else begin
          want = pending_picks.pop_front();
          if (out_chosen_key !== want.key) begin
            $error("chosen_key: expected %h, got %h", want.key, out_chosen_key);
            mismatch_count++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatch_count++;
          end
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    logic signed [WIN_W-1:0] w;
    logic [RND_W-1:0]        r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_ADD;
    in_entry_key = '0;
    in_entry_weight = '0;
    in_random_fraction = '0;
    out_stall = 1'b0;

    // directed: empty table, zero and negative weights, extremes, boundaries
    push_draw('0);
    push_draw('1);
    push_add(16'hFFFF, 16'sh0000);
    push_add(16'h0000, 16'sh8000);
    push_draw($urandom);
    push_draw('1);
    push_add(16'h1234, 16'sh7FFF);
    push_add(16'hA5A5, 16'shFFFF);
    push_add(16'h5A5A, 16'sh0001);
    push_draw('0);
    push_draw('1);
    push_draw(boundary_frac(2, 0));
    push_draw(boundary_frac(2, -1));
    push_draw(boundary_frac(3, 1));
    push_add(16'h8000, 16'sh4000);
    push_add(16'h7FFF, 16'sh2AAA);
    push_draw(boundary_frac(5, 0));
    push_draw(boundary_frac(5, -1));
    push_draw(32'h8000_0000);

    // random: fill the table while drawing, then keep drawing and hitting the full table
    for (int n = 0; n < 530; n++) begin
      if ($urandom_range(0, 99) < ((gen_count < MAX_ENTRIES) ? 30 : 8)) begin
        case ($urandom_range(0, 7))
          0:       w = 16'sh0000;
          1:       w = 16'sh7FFF;
          2:       w = {1'b1, 15'($urandom)};
          3:       w = WIN_W'($urandom_range(1, 15));
          default: w = WIN_W'($urandom);
        endcase
        push_add(KEY_W'($urandom), w);
      end else begin
        case ($urandom_range(0, 5))
          0:       r = $urandom_range(0, 1) ? '1 : '0;
          1, 2:    r = boundary_frac(int'($urandom_range(0, gen_count - 1)),
                                     int'($urandom_range(0, 2)) - 1);
          default: r = $urandom;
        endcase
        push_draw(r);
      end
    end
    total_items = stim_items.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (taken_count < total_items || pending_picks.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("roulette_wheel_selector_core_test: done, clean");
    end else begin
      $display("roulette_wheel_selector_core_test: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("roulette_wheel_selector_core_test: done, errors");
    $finish;
  end

endmodule
